### rtl/glyph_rom_address_mapper_assert.svh
// Assertion macros for the glyph ROM address mapper checker.
`ifndef GLYPH_ROM_ADDRESS_MAPPER_ASSERT_SVH
`define GLYPH_ROM_ADDRESS_MAPPER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define GRAM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gram assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define GRAM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gram assertion failed");

`endif

### rtl/gram_pkg.sv
`default_nettype none
package gram_pkg;

   localparam int AddrWidth  = 18;
   localparam int BytesWidth = 6;
   localparam int WidthWidth = 5;

   localparam logic [11:0] CELLS_PER_ROW = 12'd94;

   localparam logic [AddrWidth-1:0] BAND2_BASE = 18'h0AA40;
   localparam logic [AddrWidth-1:0] BAND3_BASE = 18'h21CDF;
   localparam logic [AddrWidth-1:0] BAND4_BASE = 18'h3C4A0;
   localparam logic [AddrWidth-1:0] BAND5_BASE = 18'h3D060;
   localparam logic [AddrWidth-1:0] ASCII_BASE = 18'd255968;

   localparam logic [BytesWidth-1:0] BYTES_HALF = 6'd16;
   localparam logic [BytesWidth-1:0] BYTES_FULL = 6'd32;
   localparam logic [WidthWidth-1:0] WIDTH_HALF = 5'd8;
   localparam logic [WidthWidth-1:0] WIDTH_FULL = 5'd16;

   localparam logic OP_KUTEN = 1'b0;
   localparam logic OP_SJIS  = 1'b1;

   typedef struct packed {
      logic [7:0] row;
      logic [7:0] cell_no;
      logic       legal;
   } kuten_type;

   typedef struct packed {
      logic [AddrWidth-1:0]  rom_address;
      logic [BytesWidth-1:0] byte_count;
      logic [WidthWidth-1:0] glyph_width;
      logic                  code_valid;
   } map_type;

endpackage
`default_nettype wire

### rtl/gram_code_decode.sv
`default_nettype none
module gram_code_decode
   import gram_pkg::*;
(
   input  wire logic       operation,
   input  wire logic [15:0] char_code,
   output kuten_type       kuten
);

   logic [7:0] hi;
   logic [7:0] lo;
   logic       lead_ok;
   logic       trail_ok;
   logic [5:0] pair;
   logic [7:0] idx;
   logic       upper;
   logic [6:0] cell_idx;

   assign hi = char_code[15:8];
   assign lo = char_code[7:0];

   assign lead_ok  = (hi >= 8'h81 && hi <= 8'h9F) || (hi >= 8'hE0 && hi <= 8'hFC);
   assign trail_ok = (lo >= 8'h40 && lo <= 8'h7E) || (lo >= 8'h80 && lo <= 8'hFC);

   // seq = pair*188 + idx, so seq/94 = 2*pair + (idx >= 94)
   assign pair     = (hi <= 8'd159) ? 6'(hi - 8'd129) : 6'(hi - 8'd193);
   assign idx      = (lo <= 8'd126) ? (lo - 8'd64) : (lo - 8'd65);
   assign upper    = (idx >= 8'd94);
   assign cell_idx = upper ? 7'(idx - 8'd94) : idx[6:0];

   always_comb begin
      if (operation == OP_SJIS) begin
         kuten.row     = {1'b0, pair, upper} + 8'd1;
         kuten.cell_no = {1'b0, cell_idx} + 8'd1;
         kuten.legal   = lead_ok && trail_ok;
      end else begin
         kuten.row     = hi;
         kuten.cell_no = lo;
         kuten.legal   = 1'b1;
      end
   end

endmodule
`default_nettype wire

### rtl/gram_band_map.sv
`default_nettype none
module gram_band_map
   import gram_pkg::*;
(
   input  kuten_type kuten,
   output map_type   result
);

   logic                 cell_ok;
   logic                 mapped;
   logic [6:0]           row_off;
   logic [AddrWidth-1:0] base;
   logic [11:0]          glyph_index;
   logic [6:0]           ascii_index;
   logic [7:0]           row;
   logic [7:0]           cell_no;

   assign row     = kuten.row;
   assign cell_no = kuten.cell_no;
   assign cell_ok = (cell_no >= 8'd1) && (cell_no <= 8'(CELLS_PER_ROW));

   always_comb begin
      mapped  = 1'b1;
      row_off = '0;
      base    = '0;
      priority if (cell_ok && row >= 8'd1 && row <= 8'd15) begin
         row_off = 7'(row - 8'd1);
      end else if (cell_ok && row >= 8'd16 && row <= 8'd47) begin
         row_off = 7'(row - 8'd16);
         base    = BAND2_BASE;
      end else if (cell_ok && row >= 8'd48 && row <= 8'd84) begin
         row_off = 7'(row - 8'd48);
         base    = BAND3_BASE;
      end else if (cell_ok && row == 8'd85) begin
         base    = BAND4_BASE;
      end else if (cell_ok && row >= 8'd88 && row <= 8'd89) begin
         row_off = 7'(row - 8'd88);
         base    = BAND5_BASE;
      end else begin
         mapped  = 1'b0;
      end
   end

   assign glyph_index = 12'(row_off) * CELLS_PER_ROW + 12'(cell_no - 8'd1);
   assign ascii_index = 7'(cell_no - 8'h20);

   always_comb begin
      priority if (!kuten.legal) begin
         result = '{rom_address: '0, byte_count: BYTES_FULL,
                    glyph_width: WIDTH_FULL, code_valid: 1'b0};
      end else if (row == 8'd0 && cell_no >= 8'h20 && cell_no <= 8'h7F) begin
         result = '{rom_address: {7'd0, ascii_index, 4'd0} + ASCII_BASE,
                    byte_count: BYTES_HALF, glyph_width: WIDTH_HALF, code_valid: 1'b1};
      end else if (mapped) begin
         result = '{rom_address: {1'b0, glyph_index, 5'd0} + base,
                    byte_count: BYTES_FULL, glyph_width: WIDTH_FULL, code_valid: 1'b1};
      end else begin
         result = '{rom_address: '0, byte_count: BYTES_FULL,
                    glyph_width: WIDTH_FULL, code_valid: 1'b0};
      end
   end

endmodule
`default_nettype wire

### rtl/glyph_rom_address_mapper.sv
`default_nettype none
// Glyph ROM address mapper.
// Input: an item is taken on a rising edge with start high and busy low.
//   req_operation selects kuten (0) or Shift-JIS (1); req_char_code holds the
//   row/lead byte high and the cell/trail byte low.
// Output: rsp_valid is high for one cycle per item with the font ROM byte
//   address, bitmap byte count, glyph width and the mapped flag.
// Pipeline: an accepted item passes the input register, then the result
//   register after the decode and band lookup, before rsp_valid rises.
// Throughput: one item per cycle; once busy drops after reset it stays low.
// Reset: synchronous, active high; drops any item in flight and holds busy
//   high until the first clock edge that samples reset low.
// The receiver has no stall: each result is shown for exactly one cycle.
module glyph_rom_address_mapper
   import gram_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_operation,
   input  wire logic [15:0]           req_char_code,
   output logic                       rsp_valid,
   output logic [AddrWidth-1:0]       rsp_rom_address,
   output logic [BytesWidth-1:0]      rsp_byte_count,
   output logic [WidthWidth-1:0]      rsp_glyph_width,
   output logic                       rsp_code_valid
);

   logic        busy_ff;
   logic        stage_valid_ff;
   logic        stage_valid_in;
   logic        op_ff;
   logic [15:0] code_ff;
   logic        rsp_valid_ff;
   map_type     result_ff;
   map_type     result_in;
   kuten_type   kuten;

   assign stage_valid_in = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         busy_ff        <= 1'b0;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_in) begin
         op_ff   <= req_operation;
         code_ff <= req_char_code;
      end
      if (stage_valid_ff) begin
         result_ff <= result_in;
      end
   end

   gram_code_decode u_decode (
      .operation (op_ff),
      .char_code (code_ff),
      .kuten     (kuten)
   );

   gram_band_map u_map (
      .kuten  (kuten),
      .result (result_in)
   );

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rom_address = result_ff.rom_address;
   assign rsp_byte_count  = result_ff.byte_count;
   assign rsp_glyph_width = result_ff.glyph_width;
   assign rsp_code_valid  = result_ff.code_valid;

endmodule
`default_nettype wire

### rtl/gram_checker.sv
`default_nettype none
`include "glyph_rom_address_mapper_assert.svh"
module gram_checker
   import gram_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  rsp_valid,
   input wire logic [AddrWidth-1:0]  rsp_rom_address,
   input wire logic [BytesWidth-1:0] rsp_byte_count,
   input wire logic [WidthWidth-1:0] rsp_glyph_width,
   input wire logic                  rsp_code_valid
);

   logic unmapped_fields;
   logic half_fields;

   assign unmapped_fields = (rsp_rom_address == '0) && (rsp_byte_count == BYTES_FULL)
                            && (rsp_glyph_width == WIDTH_FULL);
   assign half_fields     = (rsp_glyph_width == WIDTH_HALF) && rsp_code_valid;

   // accepted items bring rsp_valid through both registers, no lost or invented items
   `GRAM_ASSERT_NEXT(a_latency, start && !busy, ##1 rsp_valid)
   `GRAM_ASSERT_NEXT(a_no_spurious, !(start && !busy), ##1 !rsp_valid)
   `GRAM_ASSERT_IMPL(a_unmapped, rsp_valid && !rsp_code_valid, unmapped_fields)
   `GRAM_ASSERT_IMPL(a_half_width, rsp_valid && rsp_byte_count == BYTES_HALF, half_fields)

endmodule

bind glyph_rom_address_mapper gram_checker u_gram_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_rom_address (rsp_rom_address),
   .rsp_byte_count  (rsp_byte_count),
   .rsp_glyph_width (rsp_glyph_width),
   .rsp_code_valid  (rsp_code_valid)
);
`default_nettype wire

### verif/tb_glyph_rom_address_mapper.sv
`default_nettype none
module tb_glyph_rom_address_mapper;
   import gram_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ROW_CELLS   = CELLS_PER_ROW;
   localparam int unsigned ASCII_FIRST = 8'h20;
   localparam int unsigned ASCII_LAST  = 8'h7F;
   localparam int unsigned LEAD_SPLIT  = 159;
   localparam int unsigned TRAIL_SPLIT = 126;
   localparam int unsigned PAIR_CELLS  = 188;
   localparam int unsigned RANDOM_ITEMS = 600;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   typedef struct {
      logic        op;
      logic [15:0] code;
      int unsigned gap;
      bit          drain;
   } char_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic req_operation = 1'b0;
   logic [15:0] req_char_code = 16'h0000;
   logic busy;
   logic rsp_valid;
   logic [AddrWidth-1:0]  rsp_rom_address;
   logic [BytesWidth-1:0] rsp_byte_count;
   logic [WidthWidth-1:0] rsp_glyph_width;
   logic rsp_code_valid;

   char_item_type char_items[$];
   map_type       glyph_expected[$];
   int unsigned   error_count = 0;
   int unsigned   cycle_count = 0;

   glyph_rom_address_mapper dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_rom_address (rsp_rom_address),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_glyph_width (rsp_glyph_width),
      .rsp_code_valid  (rsp_code_valid)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic map_type map_kuten_glyph(input logic [7:0] row, input logic [7:0] cell_no);
      map_type     m;
      int unsigned r;
      int unsigned c;
      int unsigned addr;
      bit          cell_ok;
      r = row;
      c = cell_no;
      cell_ok = (c >= 1) && (c <= ROW_CELLS);
      addr = 0;
      m.byte_count  = BYTES_FULL;
      m.glyph_width = WIDTH_FULL;
      m.code_valid  = 1'b1;
      if (r == 0 && c >= ASCII_FIRST && c <= ASCII_LAST) begin
         addr = (c - ASCII_FIRST) * 16 + ASCII_BASE;
         m.byte_count  = BYTES_HALF;
         m.glyph_width = WIDTH_HALF;
      end else if (cell_ok && r >= 1 && r <= 15) begin
         addr = ((r - 1) * ROW_CELLS + c - 1) * 32;
      end else if (cell_ok && r >= 16 && r <= 47) begin
         addr = ((r - 16) * ROW_CELLS + c - 1) * 32 + BAND2_BASE;
      end else if (cell_ok && r >= 48 && r <= 84) begin
         addr = ((r - 48) * ROW_CELLS + c - 1) * 32 + BAND3_BASE;
      end else if (cell_ok && r == 85) begin
         addr = (c - 1) * 32 + BAND4_BASE;
      end else if (cell_ok && r >= 88 && r <= 89) begin
         addr = ((r - 88) * ROW_CELLS + c - 1) * 32 + BAND5_BASE;
      end else begin
         m.code_valid = 1'b0;
      end
      m.rom_address = addr[AddrWidth-1:0];
      return m;
   endfunction

   function automatic map_type predict_glyph(input logic op, input logic [15:0] code);
      map_type     m;
      int unsigned lead;
      int unsigned trail;
      int unsigned seq;
      bit          lead_ok;
      bit          trail_ok;
      logic [7:0]  row;
      logic [7:0]  cell_no;
      lead  = code[15:8];
      trail = code[7:0];
      if (op == OP_KUTEN) begin
         m = map_kuten_glyph(code[15:8], code[7:0]);
      end else begin
         lead_ok  = (lead >= 8'h81 && lead <= 8'h9F) || (lead >= 8'hE0 && lead <= 8'hFC);
         trail_ok = (trail >= 8'h40 && trail <= 8'h7E) || (trail >= 8'h80 && trail <= 8'hFC);
         if (!lead_ok || !trail_ok) begin
            m.rom_address = '0;
            m.byte_count  = BYTES_FULL;
            m.glyph_width = WIDTH_FULL;
            m.code_valid  = 1'b0;
         end else begin
            seq = ((lead <= LEAD_SPLIT) ? lead - 129 : lead - 193) * PAIR_CELLS
                  + ((trail <= TRAIL_SPLIT) ? trail - 64 : trail - 65);
            row     = 8'(seq / ROW_CELLS + 1);
            cell_no = 8'(seq % ROW_CELLS + 1);
            m = map_kuten_glyph(row, cell_no);
         end
      end
      return m;
   endfunction

   function automatic int unsigned random_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_item(input logic op, input logic [15:0] code, input int unsigned gap,
                           input bit drain);
      char_item_type item;
      item.op    = op;
      item.code  = code;
      item.gap   = gap;
      item.drain = drain;
      char_items.push_back(item);
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : drive_items
      logic          start_next;
      char_item_type item;
      start_next = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            glyph_expected.push_back(predict_glyph(req_operation, req_char_code));
         end
         if (start && busy) begin
            start_next = 1'b1;
         end else if (char_items.size() != 0) begin
            if (char_items[0].gap != 0) begin
               char_items[0].gap--;
            end else if (!(char_items[0].drain && glyph_expected.size() != 0)) begin
               item = char_items.pop_front();
               req_operation <= item.op;
               req_char_code <= item.code;
               start_next = 1'b1;
            end
         end
         start <= start_next;
      end
   end

   always @(posedge clock) begin : check_results
      map_type want;
      if (!reset && rsp_valid) begin
         if (glyph_expected.size() == 0) begin
            report_mismatch($sformatf("result with no item pending, addr %h", rsp_rom_address));
         end else begin
            want = glyph_expected.pop_front();
            if (rsp_rom_address !== want.rom_address)
               report_mismatch($sformatf("rom_address got %h want %h",
                                         rsp_rom_address, want.rom_address));
            if (rsp_byte_count !== want.byte_count)
               report_mismatch($sformatf("byte_count got %0d want %0d",
                                         rsp_byte_count, want.byte_count));
            if (rsp_glyph_width !== want.glyph_width)
               report_mismatch($sformatf("glyph_width got %0d want %0d",
                                         rsp_glyph_width, want.glyph_width));
            if (rsp_code_valid !== want.code_valid)
               report_mismatch($sformatf("code_valid got %b want %b",
                                         rsp_code_valid, want.code_valid));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("glyph_rom_address_mapper verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned i;
      int unsigned kind;
      int unsigned gap;
      logic [7:0]  hi;
      logic [7:0]  lo;

      // half-width ASCII bounds and kuten band bounds
      add_item(OP_KUTEN, 16'h0020, 0, 0);
      add_item(OP_KUTEN, 16'h007F, 0, 0);
      add_item(OP_KUTEN, 16'h001F, 1, 0);
      add_item(OP_KUTEN, 16'h0080, 0, 0);
      add_item(OP_KUTEN, 16'h0101, 0, 0);
      add_item(OP_KUTEN, 16'h015E, 0, 0);
      add_item(OP_KUTEN, 16'h0100, 2, 0);
      add_item(OP_KUTEN, 16'h015F, 0, 0);
      add_item(OP_KUTEN, 16'h1001, 0, 0);
      add_item(OP_KUTEN, 16'h2F5E, 0, 0);
      add_item(OP_KUTEN, 16'h3001, 0, 0);
      add_item(OP_KUTEN, 16'h545E, 0, 0);
      add_item(OP_KUTEN, 16'h5501, 0, 0);
      add_item(OP_KUTEN, 16'h555E, 0, 0);
      add_item(OP_KUTEN, 16'h5801, 0, 0);
      add_item(OP_KUTEN, 16'h595E, 0, 0);
      add_item(OP_KUTEN, 16'h5A01, 0, 0);
      add_item(OP_KUTEN, 16'hFFFF, 0, 0);
      // Shift-JIS: range edges, illegal bytes, converted row with no band
      add_item(OP_SJIS, 16'h8140, 5, 1);
      add_item(OP_SJIS, 16'h9FFC, 0, 0);
      add_item(OP_SJIS, 16'hE040, 0, 0);
      add_item(OP_SJIS, 16'hFCFC, 0, 0);
      add_item(OP_SJIS, 16'h8080, 0, 0);
      add_item(OP_SJIS, 16'h817F, 0, 0);
      add_item(OP_SJIS, 16'h81FD, 0, 0);
      add_item(OP_SJIS, 16'h0000, 0, 0);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         gap = ((i / 50) % 3 == 1) ? 0 : random_gap();
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            hi = 8'($urandom_range(0, 95));
            lo = (hi == 0) ? 8'($urandom_range(8'h1C, 8'h83)) : 8'($urandom_range(0, 95));
            add_item(OP_KUTEN, {hi, lo}, gap, (i == 300) || ($urandom_range(0, 99) == 0));
         end else if (kind < 75) begin
            hi = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h81, 8'h9F))
                                             : 8'($urandom_range(8'hE0, 8'hFC));
            lo = 8'($urandom_range(8'h40, 8'hFC));
            add_item(OP_SJIS, {hi, lo}, gap, (i == 300) || ($urandom_range(0, 99) == 0));
         end else begin
            add_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), gap,
                     (i == 300) || ($urandom_range(0, 99) == 0));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (char_items.size() != 0 || start || glyph_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("glyph_rom_address_mapper verification clean");
      end else begin
         $display("glyph_rom_address_mapper verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

### glyph_rom_address_mapper.f
+incdir+rtl
rtl/gram_pkg.sv
rtl/gram_code_decode.sv
rtl/gram_band_map.sv
rtl/glyph_rom_address_mapper.sv
rtl/gram_checker.sv
verif/tb_glyph_rom_address_mapper.sv
